FILE: design/rmq_pkg.sv
// rmq_pkg: shared axis type for the rotation matrix to quaternion block
// no dependencies

package rmq_pkg;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2,
      AXIS_W = 2'd3
   } axis_type;

endpackage

FILE: design/rmq_sqrt_cell.sv
// rmq_sqrt_cell: one restoring step of the pipelined integer square root
// depends on rmq_pkg

module rmq_sqrt_cell import rmq_pkg::*; #(
   parameter int RW    = 48,
   parameter int STEP  = 0,
   parameter int PW    = 160
) (
   input  logic          clock,
   input  logic [RW-1:0] rem_in,
   input  logic [RW-1:0] rad_in,
   input  logic [RW-1:0] root_in,
   input  logic [PW-1:0] pass_in,
   output logic [RW-1:0] rem_out,
   output logic [RW-1:0] rad_out,
   output logic [RW-1:0] root_out,
   output logic [PW-1:0] pass_out
);

   logic [RW+1:0] trial;
   logic [RW+1:0] cur;
   logic [RW-1:0] rem_ff, rad_ff, root_ff;
   logic [PW-1:0] pass_ff;

   always_comb begin
      cur   = {rem_in, rad_in[RW-1 -: 2]};
      trial = {root_in, 2'b01};
   end

   always_ff @(posedge clock) begin
      if (cur >= trial) begin
         rem_ff  <= RW'(cur - trial);
         root_ff <= {root_in[RW-2:0], 1'b1};
      end else begin
         rem_ff  <= RW'(cur);
         root_ff <= {root_in[RW-2:0], 1'b0};
      end
      rad_ff  <= {rad_in[RW-3:0], 2'b00};
      pass_ff <= pass_in;
   end

   assign rem_out  = rem_ff;
   assign rad_out  = rad_ff;
   assign root_out = root_ff;
   assign pass_out = pass_ff;

   logic unused_step;
   assign unused_step = (STEP < 0);

endmodule

FILE: design/rmq_div_cell.sv
// rmq_div_cell: one quotient bit of three parallel restoring dividers
// depends on rmq_pkg

module rmq_div_cell import rmq_pkg::*; #(
   parameter int NW = 40,
   parameter int SW = 24,
   parameter int PW = 100
) (
   input  logic              clock,
   input  logic [2:0][NW-1:0] num_in,
   input  logic [2:0][SW:0]   rem_in,
   input  logic [SW-1:0]      den_in,
   input  logic [PW-1:0]      pass_in,
   output logic [2:0][NW-1:0] num_out,
   output logic [2:0][SW:0]   rem_out,
   output logic [SW-1:0]      den_out,
   output logic [PW-1:0]      pass_out
);

   logic [2:0][NW-1:0] num_ff;
   logic [2:0][SW:0]   rem_ff;
   logic [SW-1:0]      den_ff;
   logic [PW-1:0]      pass_ff;
   logic [2:0][SW+1:0] cur;

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         cur[l] = {rem_in[l], num_in[l][NW-1]};
      end
   end

   always_ff @(posedge clock) begin
      for (int l = 0; l < 3; l++) begin
         if (cur[l] >= {2'b00, den_in}) begin
            rem_ff[l] <= (SW+1)'(cur[l] - {2'b00, den_in});
            num_ff[l] <= {num_in[l][NW-2:0], 1'b1};
         end else begin
            rem_ff[l] <= (SW+1)'(cur[l]);
            num_ff[l] <= {num_in[l][NW-2:0], 1'b0};
         end
      end
      den_ff  <= den_in;
      pass_ff <= pass_in;
   end

   assign num_out  = num_ff;
   assign rem_out  = rem_ff;
   assign den_out  = den_ff;
   assign pass_out = pass_ff;

endmodule

FILE: design/rotation_matrix_to_quaternion.sv
// rotation_matrix_to_quaternion: top level, Shepperd conversion of a 3x3 matrix
// depends on rmq_pkg, rmq_sqrt_cell, rmq_div_cell

// One matrix is taken every clock cycle; busy is always low. Each result
// passes through the chain of square-root cells, one per root bit, and then the
// chain of divider cells, one per quotient bit, before it reaches the result ports.
// The result strobe lasts one cycle and cannot be held off.

module rotation_matrix_to_quaternion import rmq_pkg::*; #(
   parameter int DATA_WIDTH = 16,
   parameter int FRAC_BITS  = 14
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic                         csr_wdata,
   input  logic                         start,
   output logic                         busy,
   input  logic signed [DATA_WIDTH-1:0] req_m00,
   input  logic signed [DATA_WIDTH-1:0] req_m01,
   input  logic signed [DATA_WIDTH-1:0] req_m02,
   input  logic signed [DATA_WIDTH-1:0] req_m10,
   input  logic signed [DATA_WIDTH-1:0] req_m11,
   input  logic signed [DATA_WIDTH-1:0] req_m12,
   input  logic signed [DATA_WIDTH-1:0] req_m20,
   input  logic signed [DATA_WIDTH-1:0] req_m21,
   input  logic signed [DATA_WIDTH-1:0] req_m22,
   output logic                         rsp_valid,
   output logic signed [DATA_WIDTH-1:0] rsp_qx,
   output logic signed [DATA_WIDTH-1:0] rsp_qy,
   output logic signed [DATA_WIDTH-1:0] rsp_qz,
   output logic signed [DATA_WIDTH-1:0] rsp_qw
);

   localparam int DW  = DATA_WIDTH;
   localparam int EW  = DW + 3;              // radicand and off-diagonal sums
   localparam int RAD = EW + FRAC_BITS;      // radicand shifted, even below
   localparam int RW  = RAD + (RAD % 2);
   localparam int NS  = RW / 2;              // root bits
   localparam int SW  = NS;
   localparam int NW  = EW + FRAC_BITS;      // dividend |d| << (F-1) plus round
   localparam int NQ  = NW;                  // quotient bits
   localparam int PW  = 1 + 2 + 3 + 3 * EW + 1;

   logic rh_ff;
   always_ff @(posedge clock) begin
      if (reset) rh_ff <= 1'b0;
      else if (csr_we) rh_ff <= csr_wdata;
   end

   assign busy = 1'b0;

   // stage 0: register the matrix
   logic                  v0_ff;
   logic signed [DW-1:0]  m_ff [3][3];
   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else v0_ff <= start;
      m_ff[0][0] <= req_m00; m_ff[0][1] <= req_m01; m_ff[0][2] <= req_m02;
      m_ff[1][0] <= req_m10; m_ff[1][1] <= req_m11; m_ff[1][2] <= req_m12;
      m_ff[2][0] <= req_m20; m_ff[2][1] <= req_m21; m_ff[2][2] <= req_m22;
   end

   // stage 1: pivot, radicand and the three signed terms
   logic signed [EW-1:0] tr, rad_c, d_c [3];
   logic [1:0] piv_c;
   logic signed [EW-1:0] one;
   logic signed [EW-1:0] a00, a11, a22;
   always_comb begin
      one = EW'(1) <<< FRAC_BITS;
      a00 = EW'(m_ff[0][0]); a11 = EW'(m_ff[1][1]); a22 = EW'(m_ff[2][2]);
      tr  = a00 + a11 + a22;
      piv_c = AXIS_X;
      if (a11 > a00) piv_c = AXIS_Y;
      if (a22 > ((piv_c == AXIS_Y) ? a11 : a00)) piv_c = AXIS_Z;
      if (tr > 0) begin
         piv_c = AXIS_W;
         rad_c = tr + one;
         if (rh_ff) begin
            d_c[0] = EW'(m_ff[2][1]) - EW'(m_ff[1][2]);
            d_c[1] = EW'(m_ff[0][2]) - EW'(m_ff[2][0]);
         end else begin
            d_c[0] = EW'(m_ff[1][2]) - EW'(m_ff[2][1]);
            d_c[1] = EW'(m_ff[2][0]) - EW'(m_ff[0][2]);
         end
         d_c[2] = EW'(m_ff[0][1]) - EW'(m_ff[1][0]);
      end else begin
         case (piv_c)
            AXIS_X: begin
               rad_c  = a00 - (a11 + a22) + one;
               d_c[0] = EW'(m_ff[0][1]) + EW'(m_ff[1][0]);   // y
               d_c[1] = EW'(m_ff[0][2]) + EW'(m_ff[2][0]);   // z
               d_c[2] = rh_ff ? EW'(m_ff[2][1]) - EW'(m_ff[1][2])
                              : EW'(m_ff[1][2]) - EW'(m_ff[2][1]);
            end
            AXIS_Y: begin
               rad_c  = a11 - (a22 + a00) + one;
               d_c[0] = EW'(m_ff[1][2]) + EW'(m_ff[2][1]);   // z
               d_c[1] = EW'(m_ff[1][0]) + EW'(m_ff[0][1]);   // x
               d_c[2] = rh_ff ? EW'(m_ff[0][2]) - EW'(m_ff[2][0])
                              : EW'(m_ff[2][0]) - EW'(m_ff[0][2]);
            end
            default: begin
               rad_c  = a22 - (a00 + a11) + one;
               d_c[0] = EW'(m_ff[2][0]) + EW'(m_ff[0][2]);   // x
               d_c[1] = EW'(m_ff[2][1]) + EW'(m_ff[1][2]);   // y
               d_c[2] = EW'(m_ff[0][1]) - EW'(m_ff[1][0]);
            end
         endcase
      end
   end

   logic v1_ff;
   logic [1:0] piv1_ff;
   logic signed [EW-1:0] rad1_ff, d1_ff [3];
   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else v1_ff <= v0_ff;
      piv1_ff <= piv_c;
      rad1_ff <= rad_c;
      d1_ff   <= d_c;
   end

   // stage 2: magnitudes, signs, shifted radicand
   logic [PW-1:0] pass2;
   logic [RW-1:0] radsh;
   logic [2:0]    sgn;
   logic [2:0][EW-1:0] mag;
   always_comb begin
      radsh = (rad1_ff > 0) ? (RW'($unsigned(rad1_ff)) << FRAC_BITS) : '0;
      for (int l = 0; l < 3; l++) begin
         sgn[l] = d1_ff[l][EW-1];
         mag[l] = sgn[l] ? EW'(-d1_ff[l]) : EW'(d1_ff[l]);
      end
      pass2 = {v1_ff, piv1_ff, sgn, mag[2], mag[1], mag[0], 1'b0};
   end

   logic [RW-1:0] s_rem [NS+1];
   logic [RW-1:0] s_rad [NS+1];
   logic [RW-1:0] s_root [NS+1];
   logic [PW-1:0] s_pass [NS+1];
   always_ff @(posedge clock) begin
      s_rad[0]  <= radsh;
      s_pass[0] <= reset ? '0 : pass2;
   end
   assign s_rem[0]  = '0;
   assign s_root[0] = '0;

   for (genvar g = 0; g < NS; g++) begin : g_sqrt
      rmq_sqrt_cell #(.RW(RW), .STEP(g), .PW(PW)) u_cell (
         .clock   (clock),
         .rem_in  (s_rem[g]),
         .rad_in  (s_rad[g]),
         .root_in (s_root[g]),
         .pass_in (reset ? '0 : s_pass[g]),
         .rem_out (s_rem[g+1]),
         .rad_out (s_rad[g+1]),
         .root_out(s_root[g+1]),
         .pass_out(s_pass[g+1])
      );
   end

   // divider setup: dividend = |d| << (F-1) + s/2, divisor s
   logic [SW-1:0] root;
   logic [PW-1:0] pp;
   logic [2:0][NW-1:0] num0;
   logic [SW-1:0] half_c;
   always_comb begin
      root = SW'(s_root[NS]);
      pp   = s_pass[NS];
      for (int l = 0; l < 3; l++) begin
         num0[l] = (NW'(pp[1 + l*EW +: EW]) << (FRAC_BITS - 1)) + NW'(root >> 1);
      end
      half_c = SW'((NW'(root) + NW'(1)) >> 1);
   end

   localparam int QW = PW + SW;
   logic [2:0][NW-1:0] dv_num [NQ+1];
   logic [2:0][SW:0]   dv_rem [NQ+1];
   logic [SW-1:0]      dv_den [NQ+1];
   logic [QW-1:0]      dv_pass [NQ+1];
   always_ff @(posedge clock) begin
      dv_num[0]  <= num0;
      dv_den[0]  <= root;
      dv_pass[0] <= reset ? '0 : {pp, half_c};
   end
   assign dv_rem[0] = '0;

   for (genvar g = 0; g < NQ; g++) begin : g_div
      rmq_div_cell #(.NW(NW), .SW(SW), .PW(QW)) u_cell (
         .clock   (clock),
         .num_in  (dv_num[g]),
         .rem_in  (dv_rem[g]),
         .den_in  (dv_den[g]),
         .pass_in (reset ? '0 : dv_pass[g]),
         .num_out (dv_num[g+1]),
         .rem_out (dv_rem[g+1]),
         .den_out (dv_den[g+1]),
         .pass_out(dv_pass[g+1])
      );
   end

   // output: sign, zero root, saturation, placement
   function automatic logic signed [DW-1:0] sat_fn(input logic signed [NW+1:0] v);
      logic signed [NW+1:0] hi, lo;
      hi = (NW+2)'((64'sd1 <<< (DW-1)) - 1);
      lo = -hi - 1;
      if (v > hi) sat_fn = DW'(hi);
      else if (v < lo) sat_fn = DW'(lo);
      else sat_fn = DW'(v);
   endfunction

   logic [QW-1:0] fp;
   logic [PW-1:0] fpp;
   logic [SW-1:0] fhalf, fden;
   logic          fv;
   logic [1:0]    fpiv;
   logic [2:0]    fsgn;
   logic signed [DW-1:0] t [3];
   logic signed [DW-1:0] h;
   logic signed [NW+1:0] sq;
   logic signed [DW-1:0] ox, oy, oz, ow;
   always_comb begin
      fp    = dv_pass[NQ];
      fden  = dv_den[NQ];
      fhalf = fp[SW-1:0];
      fpp   = fp[QW-1:SW];
      fv    = fpp[PW-1];
      fpiv  = fpp[PW-2 -: 2];
      fsgn  = fpp[PW-4 -: 3];
      for (int l = 0; l < 3; l++) begin
         sq = (NW+2)'({2'b00, dv_num[NQ][l]});
         if (fsgn[l]) sq = -sq;
         t[l] = (fden == '0) ? '0 : sat_fn(sq);
      end
      h = sat_fn((NW+2)'(fhalf));
      case (fpiv)
         AXIS_W: begin ox = t[0]; oy = t[1]; oz = t[2]; ow = h; end
         AXIS_X: begin ox = h; oy = t[0]; oz = t[1]; ow = t[2]; end
         AXIS_Y: begin ox = t[1]; oy = h; oz = t[0]; ow = t[2]; end
         default: begin ox = t[0]; oy = t[1]; oz = h; ow = t[2]; end
      endcase
   end

   logic rv_ff;
   logic signed [DW-1:0] qx_ff, qy_ff, qz_ff, qw_ff;
   always_ff @(posedge clock) begin
      if (reset) rv_ff <= 1'b0;
      else rv_ff <= fv;
      qx_ff <= ox; qy_ff <= oy; qz_ff <= oz; qw_ff <= ow;
   end

   assign rsp_valid = rv_ff;
   assign rsp_qx = qx_ff;
   assign rsp_qy = qy_ff;
   assign rsp_qz = qz_ff;
   assign rsp_qw = qw_ff;

   logic unused_bit;
   assign unused_bit = ^{fpp[PW-7:0], dv_rem[NQ], s_rem[NS], s_rad[NS]};

endmodule

FILE: tb/tb.sv
// tb: self-checking testbench for rotation_matrix_to_quaternion
// predicts each quaternion in the testbench and checks every result beat
// depends on rmq_pkg and the rotation_matrix_to_quaternion RTL
`timescale 1ns / 1ps

module tb;
   import rmq_pkg::*;

   localparam int DW = 16;
   localparam int FB = 14;
   localparam int LATENCY = 4 + (DW + FB + 4) / 2 + (DW + FB + 3);

   typedef logic signed [DW-1:0] elem_t;
   typedef struct packed {
      elem_t qx;
      elem_t qy;
      elem_t qz;
      elem_t qw;
   } quat_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic csr_wdata = 1'b0;
   logic start = 1'b0;
   logic busy;
   elem_t req_m [9];
   logic rsp_valid;
   elem_t rsp_qx, rsp_qy, rsp_qz, rsp_qw;

   logic handed_mode = 1'b0;
   quat_t quat_queue[$];
   int error_count = 0;
   int beat_count = 0;
   int result_count = 0;
   bit idle_on = 1'b1;

   rotation_matrix_to_quaternion DUT (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .start(start), .busy(busy),
      .req_m00(req_m[0]), .req_m01(req_m[1]), .req_m02(req_m[2]),
      .req_m10(req_m[3]), .req_m11(req_m[4]), .req_m12(req_m[5]),
      .req_m20(req_m[6]), .req_m21(req_m[7]), .req_m22(req_m[8]),
      .rsp_valid(rsp_valid), .rsp_qx(rsp_qx), .rsp_qy(rsp_qy),
      .rsp_qz(rsp_qz), .rsp_qw(rsp_qw)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      foreach (req_m[n]) req_m[n] = '0;
   end

   function automatic longint unsigned int_root(longint unsigned x);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv >>= 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned fixed_root(longint r);
      if (r <= 0) return 0;
      return int_root(longint'(r) << FB);
   endfunction

   function automatic longint half_over_root(longint d, longint unsigned s);
      longint unsigned mag, q;
      if (s == 0) return 0;
      mag = d < 0 ? -d : d;
      q = ((mag << (FB - 1)) + (s >> 1)) / s;
      return d < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic elem_t clamp(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return elem_t'(v);
   endfunction

   function automatic quat_t predict_quat(elem_t e [9]);
      longint m [3][3];
      longint q [4];
      longint tr;
      longint unsigned s;
      int i, j, k;
      quat_t res;
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++) m[r][c] = e[r * 3 + c];
      tr = m[0][0] + m[1][1] + m[2][2];
      if (tr > 0) begin
         s = fixed_root(tr + (64'sd1 << FB));
         q[AXIS_W] = longint'((s + 1) >> 1);
         if (handed_mode) begin
            q[AXIS_X] = half_over_root(m[2][1] - m[1][2], s);
            q[AXIS_Y] = half_over_root(m[0][2] - m[2][0], s);
         end else begin
            q[AXIS_X] = half_over_root(m[1][2] - m[2][1], s);
            q[AXIS_Y] = half_over_root(m[2][0] - m[0][2], s);
         end
         q[AXIS_Z] = half_over_root(m[0][1] - m[1][0], s);
      end else begin
         i = 0;
         if (m[1][1] > m[0][0]) i = 1;
         if (m[2][2] > m[i][i]) i = 2;
         j = (i + 1) % 3;
         k = (j + 1) % 3;
         s = fixed_root(m[i][i] - (m[j][j] + m[k][k]) + (64'sd1 << FB));
         q[i] = longint'((s + 1) >> 1);
         if (handed_mode && i != AXIS_Z) q[AXIS_W] = half_over_root(m[k][j] - m[j][k], s);
         else q[AXIS_W] = half_over_root(m[j][k] - m[k][j], s);
         q[j] = half_over_root(m[i][j] + m[j][i], s);
         q[k] = half_over_root(m[i][k] + m[k][i], s);
      end
      res.qx = clamp(q[AXIS_X]);
      res.qy = clamp(q[AXIS_Y]);
      res.qz = clamp(q[AXIS_Z]);
      res.qw = clamp(q[AXIS_W]);
      return res;
   endfunction

   task automatic report_mismatch(string what, elem_t got, elem_t want);
      $display("mismatch %s at result %0d: got %0d want %0d", what, result_count, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      quat_t want;
      if (!reset && rsp_valid) begin
         if (quat_queue.size() == 0) begin
            $display("unexpected result beat %0d", result_count);
            error_count++;
         end else begin
            want = quat_queue.pop_front();
            if (rsp_qx !== want.qx) report_mismatch("qx", rsp_qx, want.qx);
            if (rsp_qy !== want.qy) report_mismatch("qy", rsp_qy, want.qy);
            if (rsp_qz !== want.qz) report_mismatch("qz", rsp_qz, want.qz);
            if (rsp_qw !== want.qw) report_mismatch("qw", rsp_qw, want.qw);
         end
         result_count++;
      end
   end

   // one matrix beat, with random idle cycles ahead of it while idle_on is set
   task automatic send_matrix(elem_t e [9]);
      while (idle_on && $urandom_range(99) < 18) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      foreach (e[n]) req_m[n] <= e[n];
      do @(posedge clock); while (busy);
      quat_queue.push_back(predict_quat(e));
      beat_count++;
   endtask

   task automatic drain();
      start <= 1'b0;
      while (quat_queue.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_mode(logic v);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      handed_mode = v;
   endtask

   function automatic elem_t rand_elem();
      case ($urandom_range(5))
         0: return 16'sh7fff;
         1: return 16'sh8000;
         2: return elem_t'($urandom_range(32767) - 16384);
         default: return elem_t'($urandom);
      endcase
   endfunction

   task automatic send_rotation();
      elem_t e [9];
      longint a, b, c, d, n2;
      a = longint'($urandom_range(32767)) - 16384;
      b = longint'($urandom_range(32767)) - 16384;
      c = longint'($urandom_range(32767)) - 16384;
      d = longint'($urandom_range(32767)) - 16384;
      n2 = (a * a + b * b + c * c + d * d) >> FB;
      if (n2 == 0) n2 = 1;
      // unit quaternion (a,b,c,d) = (w,x,y,z) to a rotation matrix
      e[0] = clamp((64'sd1 << FB) - 2 * (c * c + d * d) / n2);
      e[1] = clamp(2 * (b * c - d * a) / n2);
      e[2] = clamp(2 * (b * d + c * a) / n2);
      e[3] = clamp(2 * (b * c + d * a) / n2);
      e[4] = clamp((64'sd1 << FB) - 2 * (b * b + d * d) / n2);
      e[5] = clamp(2 * (c * d - b * a) / n2);
      e[6] = clamp(2 * (b * d - c * a) / n2);
      e[7] = clamp(2 * (c * d + b * a) / n2);
      e[8] = clamp((64'sd1 << FB) - 2 * (b * b + c * c) / n2);
      if ($urandom_range(3) == 0) e[$urandom_range(8)] = rand_elem();
      send_matrix(e);
   endtask

   task automatic test_directed();
      elem_t e [9];
      int one;
      one = 1 << FB;
      for (int t = 0; t < 12; t++) begin
         foreach (e[n]) e[n] = '0;
         case (t)
            0: begin e[0] = one; e[4] = one; e[8] = one; end
            1: foreach (e[n]) e[n] = 16'sh7fff;
            2: foreach (e[n]) e[n] = 16'sh8000;
            3: begin e[0] = one; e[4] = -one; e[8] = -one; end
            4: begin e[0] = -one; e[4] = one; e[8] = -one; end
            5: begin e[0] = -one; e[4] = -one; e[8] = one; e[1] = 100; e[5] = -77; end
            6: begin e[0] = -one; e[4] = -one; e[8] = -one; end
            7: begin e[0] = 100; e[4] = 100; e[8] = -200; e[2] = 5; end
            8: begin e[0] = 0; e[4] = 0; e[8] = 0; e[7] = 16'sh7fff; e[5] = 16'sh8000; end
            9: begin e[4] = 16'sh7fff; e[8] = 16'sh7fff; e[0] = 16'sh8000; end
            10: begin e[0] = 1; e[1] = 16'sh7fff; e[3] = 16'sh8000; e[6] = 16'sh7fff; end
            11: begin e[0] = -one; e[4] = -one; e[8] = -one; e[1] = 16'sh7fff; end
         endcase
         send_matrix(e);
      end
   endtask

   task automatic test_random(int count);
      elem_t e [9];
      for (int n = 0; n < count; n++) begin
         if (n == count / 2) idle_on = 1'b0;
         if (n == count / 2 + 60) idle_on = 1'b1;
         if ($urandom_range(9) < 6) send_rotation();
         else begin
            foreach (e[k]) e[k] = rand_elem();
            send_matrix(e);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      drain();
      write_mode(1'b1);
      test_directed();
      test_random(150);
      drain();
      write_mode(1'b0);
      test_random(150);
      drain();
      write_mode(1'b1);
      test_random(150);
      drain();
      write_mode(1'b0);
      test_random(126);
      drain();
      $display("covered %0d matrix beats and %0d results in both handedness modes",
               beat_count, result_count);
      if (error_count == 0) $display("tb: clean");
      else $display("tb: errors");
      $finish;
   end

   initial begin
      #2000000;
      $display("tb: errors");
      $finish;
   end

endmodule

FILE: sim.f
design/rmq_pkg.sv
design/rmq_sqrt_cell.sv
design/rmq_div_cell.sv
design/rotation_matrix_to_quaternion.sv
tb/tb.sv
